>>> rtl/core/oren_nayar_brdf_eval_macros.svh
// Assertion helpers, sampled on clk_i and quiet while rst_ni is low.
`ifndef OREN_NAYAR_BRDF_EVAL_MACROS_SVH
`define OREN_NAYAR_BRDF_EVAL_MACROS_SVH

`define ONB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ONB_ASSERT_IMPL(lbl, ante, cons, msg) \
  `ONB_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> rtl/core/onb_pkg.sv
package onb_pkg;

  localparam logic [15:0] Q15_ONE    = 16'd32768;
  localparam logic [30:0] Q30_ONE    = 31'd1073741824;
  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
  localparam logic [15:0] SAT16      = 16'hFFFF;

  localparam int unsigned SQRT_STAGES = 16;
  localparam int unsigned DIV_STAGES  = 31;

  typedef enum logic [7:0] {
    CFG_COEF_A = 8'd0,
    CFG_COEF_B = 8'd1
  } cfg_idx_e;

  // directions: [0] in x, [1] in y, [2] out x, [3] out y
  typedef struct packed {
    logic             vld;
    logic             same;
    logic [15:0]      pdf;
    logic [2:0][15:0] alb;
    logic [15:0]      izm;
    logic [15:0]      ozm;
    logic [3:0][15:0] mag;
    logic [3:0]       neg;
  } side_a_t;

  typedef struct packed {
    logic             vld;
    logic             same;
    logic [15:0]      pdf;
    logic [2:0][15:0] alb;
    logic [15:0]      ozm;
    logic [15:0]      sina;
    logic [3:0]       neg;
    logic             pole_i;
    logic             pole_o;
  } side_b_t;

endpackage

>>> rtl/core/onb_delay.sv
module onb_delay import onb_pkg::*; #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) sr_q[i] <= '0;
    end else if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[N-1];

endmodule

>>> rtl/core/onb_sqrt_pipe.sv
module onb_sqrt_pipe import onb_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] rad_i,
  output logic [15:0] root_o
);

  // one result bit per stage, digit-by-digit square root
  logic [31:0] v_q [SQRT_STAGES];
  logic [31:0] r_q [SQRT_STAGES];
  logic [31:0] vc [SQRT_STAGES];
  logic [31:0] rc [SQRT_STAGES];
  logic [31:0] vn [SQRT_STAGES];
  logic [31:0] rn [SQRT_STAGES];
  logic [31:0] tr [SQRT_STAGES];

  always_comb begin
    vc[0] = {1'b0, rad_i};
    rc[0] = '0;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      vc[k] = v_q[k-1];
      rc[k] = r_q[k-1];
    end
    for (int k = 0; k < SQRT_STAGES; k++) begin
      tr[k] = rc[k] + (32'd1 << (30 - 2 * k));
      if (vc[k] >= tr[k]) begin
        vn[k] = vc[k] - tr[k];
        rn[k] = (rc[k] >> 1) + (32'd1 << (30 - 2 * k));
      end else begin
        vn[k] = vc[k];
        rn[k] = rc[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= vn;
      r_q <= rn;
    end
  end

  assign root_o = r_q[SQRT_STAGES-1][15:0];

endmodule

>>> rtl/core/onb_div_pipe.sv
module onb_div_pipe import onb_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] num_i,
  input  logic [15:0] den_i,
  output logic [30:0] quo_o
);

  // restoring divider, one quotient bit per stage; sh shifts dividend out, quotient in
  logic [15:0] rem_q [DIV_STAGES];
  logic [30:0] sh_q  [DIV_STAGES];
  logic [15:0] den_q [DIV_STAGES];
  logic [15:0] remc [DIV_STAGES];
  logic [30:0] shc  [DIV_STAGES];
  logic [15:0] denc [DIV_STAGES];
  logic [15:0] remn [DIV_STAGES];
  logic [30:0] shn  [DIV_STAGES];
  logic [16:0] t    [DIV_STAGES];
  logic [16:0] df   [DIV_STAGES];

  always_comb begin
    remc[0] = '0;
    shc[0]  = num_i;
    denc[0] = den_i;
    for (int k = 1; k < DIV_STAGES; k++) begin
      remc[k] = rem_q[k-1];
      shc[k]  = sh_q[k-1];
      denc[k] = den_q[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      t[k]  = {remc[k], shc[k][30]};
      df[k] = t[k] - {1'b0, denc[k]};
      if (t[k] >= {1'b0, denc[k]}) begin
        remn[k] = df[k][15:0];
        shn[k]  = {shc[k][29:0], 1'b1};
      end else begin
        remn[k] = t[k][15:0];
        shn[k]  = {shc[k][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= remn;
      sh_q  <= shn;
      den_q <= denc;
    end
  end

  assign quo_o = sh_q[DIV_STAGES-1];

endmodule

>>> rtl/core/onb_shade.sv
module onb_shade import onb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [4:0][30:0] quo_i,
  input  side_b_t          side_i,
  input  logic [15:0]      coef_a_i,
  input  logic [15:0]      coef_b_i,
  output logic             out_valid_o,
  output logic [2:0][15:0] fr_o,
  output logic [15:0]      pdf_o,
  output logic             same_o
);

  localparam int unsigned NS = 10;

  side_b_t sd_q [NS];

  logic signed [3:0][16:0] c_q;
  logic [30:0] tb0_q, tb1_q, tb2_q, tb3_q, tb4_q;
  logic signed [33:0] pr0_q, pr1_q;
  logic [15:0] dq_q, t1_q, t2_q;
  logic [31:0] t3_q;
  logic [32:0] g_q;
  logic [33:0] g2_q;
  logic [2:0][34:0] p_q;
  logic [2:0][15:0] fr_q;

  logic signed [3:0][16:0] c_d;
  logic [15:0]        qc;
  logic signed [34:0] dc;
  logic [15:0]        dq_d;
  logic [31:0]        m1, m2;
  logic [46:0]        m3;
  logic [48:0]        m4;
  logic [2:0][49:0]   m5;
  logic [2:0][48:0]   rnd;
  logic [2:0][15:0]   fr_d;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qc = (quo_i[k] > 31'(Q15_ONE)) ? Q15_ONE : quo_i[k][15:0];
      c_d[k] = side_i.neg[k] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    end
    // at the pole the azimuth falls back to cos 1, sin 0
    if (side_i.pole_i) begin
      c_d[0] = $signed({1'b0, Q15_ONE});
      c_d[1] = '0;
    end
    if (side_i.pole_o) begin
      c_d[2] = $signed({1'b0, Q15_ONE});
      c_d[3] = '0;
    end

    dc = 35'(pr0_q) + 35'(pr1_q);
    if (dc < 0) dq_d = '0;
    else if (dc > $signed({4'b0, Q30_ONE})) dq_d = Q15_ONE;
    else dq_d = dc[30:15];

    m1 = 32'(coef_b_i) * 32'(dq_q);
    m2 = 32'(t1_q) * 32'(sd_q[3].sina);
    m3 = 47'(t2_q) * 47'(tb4_q);
    m4 = 49'(g_q) * 49'(sd_q[6].ozm);
    for (int ch = 0; ch < 3; ch++) begin
      m5[ch]  = 50'(sd_q[7].alb[ch]) * 50'(g2_q);
      rnd[ch] = 49'(p_q[ch][16:0]) * 49'(INV_PI_Q32) + (49'd1 << 30);
      if (p_q[ch][34:17] != '0) fr_d[ch] = SAT16;
      else if (rnd[ch][48:47] != '0) fr_d[ch] = SAT16;
      else fr_d[ch] = rnd[ch][46:31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) sd_q[i] <= '0;
      out_valid_o <= 1'b0;
    end else if (en_i) begin
      sd_q[0] <= side_i;
      for (int i = 1; i < NS; i++) sd_q[i] <= sd_q[i-1];
      out_valid_o <= sd_q[NS-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q   <= c_d;
      tb0_q <= quo_i[4];
      // element selects of a packed array are unsigned
      pr0_q <= $signed(c_q[0]) * $signed(c_q[2]);
      pr1_q <= $signed(c_q[1]) * $signed(c_q[3]);
      tb1_q <= tb0_q;
      dq_q  <= dq_d;
      tb2_q <= tb1_q;
      t1_q  <= m1[30:15];
      tb3_q <= tb2_q;
      t2_q  <= m2[30:15];
      tb4_q <= tb3_q;
      t3_q  <= m3[46:15];
      g_q   <= 33'(coef_a_i) + 33'(t3_q);
      g2_q  <= m4[48:15];
      for (int ch = 0; ch < 3; ch++) p_q[ch] <= m5[ch][49:15];
      fr_q  <= fr_d;
      // opposite or grazing hemispheres give all zeros
      fr_o   <= sd_q[NS-1].same ? fr_q : '0;
      pdf_o  <= sd_q[NS-1].same ? sd_q[NS-1].pdf : '0;
      same_o <= sd_q[NS-1].same;
    end
  end

endmodule

>>> rtl/core/oren_nayar_brdf_eval.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  in_/out_ x,y,z, albedo_r/g/b
// out       output     out_valid_o/out_stall_i fr_r/g/b, pdf, same_side
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One request per cycle while the output is not stalled. The stages in order are format
// conversion and z^2, the bit-per-stage square root, the bit-per-stage dividers, and
// the shading multiplies and output register.
// Reset clears valid bits and loads coef_a/coef_b with their defaults.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module oren_nayar_brdf_eval import onb_pkg::*; #(
  parameter int unsigned DIR_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [DIR_BITS-1:0] in_x_i,
  input  logic signed [DIR_BITS-1:0] in_y_i,
  input  logic signed [DIR_BITS-1:0] in_z_i,
  input  logic signed [DIR_BITS-1:0] out_x_i,
  input  logic signed [DIR_BITS-1:0] out_y_i,
  input  logic signed [DIR_BITS-1:0] out_z_i,
  input  logic [15:0]                albedo_r_i,
  input  logic [15:0]                albedo_g_i,
  input  logic [15:0]                albedo_b_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [15:0]                fr_r_o,
  output logic [15:0]                fr_g_o,
  output logic [15:0]                fr_b_o,
  output logic [15:0]                pdf_o,
  output logic                       same_side_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [7:0]                 cfg_index_i,
  input  logic [15:0]                cfg_data_i
);

  localparam int unsigned RSH = (DIR_BITS > 16) ? DIR_BITS - 16 : 0;
  localparam int unsigned LSH = (DIR_BITS < 16) ? 16 - DIR_BITS : 0;
  localparam int unsigned MW  = DIR_BITS + 17;
  localparam logic [MW-1:0]       RND     = MW'((1 << RSH) >> 1);
  localparam logic [DIR_BITS:0]   MAG_TOP = {1'b1, {DIR_BITS{1'b0}}};
  localparam int unsigned WA = $bits(side_a_t);
  localparam int unsigned WB = $bits(side_b_t);

  // sign plus Q.15 magnitude, round half up when narrowing
  function automatic logic [16:0] to_q15(input logic [DIR_BITS-1:0] v);
    logic [DIR_BITS:0] m;
    logic [MW-1:0]     w;
    m = v[DIR_BITS-1] ? (MAG_TOP - {1'b0, v}) : {1'b0, v};
    w = ((MW'(m) + RND) >> RSH) << LSH;
    return {v[DIR_BITS-1], w[15:0]};
  endfunction

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // configuration
  logic [15:0] coef_a_q, coef_b_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= 16'd20450;
      coef_b_q <= 16'd13528;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COEF_A: coef_a_q <= cfg_data_i;
        CFG_COEF_B: coef_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: conversion
  logic [16:0] cix, ciy, ciz, cox, coy, coz;
  side_a_t s1_d, s1_q, s2_d, s2_q;

  always_comb begin
    cix = to_q15(in_x_i);
    ciy = to_q15(in_y_i);
    ciz = to_q15(in_z_i);
    cox = to_q15(out_x_i);
    coy = to_q15(out_y_i);
    coz = to_q15(out_z_i);
    s1_d.vld    = in_valid_i;
    s1_d.same   = (ciz[15:0] != '0) && (coz[15:0] != '0) && (ciz[16] == coz[16]);
    s1_d.pdf    = '0;
    s1_d.alb[0] = albedo_r_i;
    s1_d.alb[1] = albedo_g_i;
    s1_d.alb[2] = albedo_b_i;
    s1_d.izm    = ciz[15:0];
    s1_d.ozm    = coz[15:0];
    s1_d.mag[0] = cix[15:0];
    s1_d.mag[1] = ciy[15:0];
    s1_d.mag[2] = cox[15:0];
    s1_d.mag[3] = coy[15:0];
    s1_d.neg    = {coy[16], cox[16], ciy[16], cix[16]};
  end

  // stage 2: radicands and pdf
  logic [31:0] zi2, zo2;
  logic [47:0] pdf_m;
  logic [30:0] rad_i_q, rad_o_q;

  always_comb begin
    zi2   = 32'(s1_q.izm) * 32'(s1_q.izm);
    zo2   = 32'(s1_q.ozm) * 32'(s1_q.ozm);
    pdf_m = 48'(s1_q.ozm) * 48'(INV_PI_Q32) + (48'd1 << 30);
    s2_d  = s1_q;
    s2_d.pdf = (pdf_m[47] != 1'b0) ? SAT16 : pdf_m[46:31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_i_q <= Q30_ONE - zi2[30:0];
      rad_o_q <= Q30_ONE - zo2[30:0];
    end
  end

  // square roots
  logic [15:0] sti, sto;
  logic [WA-1:0] sa_vec;
  side_a_t sa;

  onb_sqrt_pipe u_sqrt_i (.clk_i, .en_i(en), .rad_i(rad_i_q), .root_o(sti));
  onb_sqrt_pipe u_sqrt_o (.clk_i, .en_i(en), .rad_i(rad_o_q), .root_o(sto));

  onb_delay #(.W(WA), .N(SQRT_STAGES)) u_dly_a (
    .clk_i, .rst_ni, .en_i(en), .d_i(s2_q), .q_o(sa_vec)
  );
  assign sa = side_a_t'(sa_vec);

  // dividers: azimuth ratios and tan beta
  logic          gt;
  logic [4:0][30:0] num, quo;
  logic [4:0][15:0] den;
  side_b_t       sb_d;
  logic [WB-1:0] sb_vec;

  always_comb begin
    gt = sti > sto;
    num[0] = {sa.mag[0], 15'b0};
    num[1] = {sa.mag[1], 15'b0};
    num[2] = {sa.mag[2], 15'b0};
    num[3] = {sa.mag[3], 15'b0};
    num[4] = gt ? {sto, 15'b0} : {sti, 15'b0};
    den[0] = sti;
    den[1] = sti;
    den[2] = sto;
    den[3] = sto;
    den[4] = gt ? sa.ozm : sa.izm;
    sb_d.vld    = sa.vld;
    sb_d.same   = sa.same;
    sb_d.pdf    = sa.pdf;
    sb_d.alb    = sa.alb;
    sb_d.ozm    = sa.ozm;
    sb_d.sina   = gt ? sti : sto;
    sb_d.neg    = sa.neg;
    sb_d.pole_i = (sti == '0);
    sb_d.pole_o = (sto == '0);
  end

  for (genvar j = 0; j < 5; j++) begin : g_div
    onb_div_pipe u_div (
      .clk_i, .en_i(en), .num_i(num[j]), .den_i(den[j]), .quo_o(quo[j])
    );
  end

  onb_delay #(.W(WB), .N(DIV_STAGES)) u_dly_b (
    .clk_i, .rst_ni, .en_i(en), .d_i(sb_d), .q_o(sb_vec)
  );

  logic [2:0][15:0] fr;

  onb_shade u_shade (
    .clk_i, .rst_ni, .en_i(en),
    .quo_i(quo), .side_i(side_b_t'(sb_vec)),
    .coef_a_i(coef_a_q), .coef_b_i(coef_b_q),
    .out_valid_o, .fr_o(fr), .pdf_o, .same_o(same_side_o)
  );

  assign fr_r_o = fr[0];
  assign fr_g_o = fr[1];
  assign fr_b_o = fr[2];

endmodule

>>> rtl/core/onb_checker.sv
`include "oren_nayar_brdf_eval_macros.svh"

module onb_checker #(
  parameter int unsigned DIR_BITS = 16
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic signed [DIR_BITS-1:0] in_x_i,
  input logic signed [DIR_BITS-1:0] in_y_i,
  input logic signed [DIR_BITS-1:0] in_z_i,
  input logic signed [DIR_BITS-1:0] out_x_i,
  input logic signed [DIR_BITS-1:0] out_y_i,
  input logic signed [DIR_BITS-1:0] out_z_i,
  input logic [15:0]                albedo_r_i,
  input logic [15:0]                albedo_g_i,
  input logic [15:0]                albedo_b_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [15:0]                fr_r_o,
  input logic [15:0]                fr_g_o,
  input logic [15:0]                fr_b_o,
  input logic [15:0]                pdf_o,
  input logic                       same_side_o,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic [7:0]                 cfg_index_i,
  input logic [15:0]                cfg_data_i
);

  logic res_zero, opp_vld, same_vld, out_wait;

  assign res_zero = (fr_r_o == '0) && (fr_g_o == '0) && (fr_b_o == '0) && (pdf_o == '0);
  assign opp_vld  = out_valid_o && !same_side_o;
  assign same_vld = out_valid_o && same_side_o;
  assign out_wait = out_valid_o && out_stall_i;

  // opposite hemispheres report nothing at all
  `ONB_ASSERT_IMPL(a_opp_zero, opp_vld, res_zero, "nonzero result for opposite hemispheres")
  // a shared hemisphere has a nonzero normal component, so pdf is never zero
  `ONB_ASSERT_IMPL(a_pdf_nz, same_vld, pdf_o != 16'd0, "zero pdf in shared hemisphere")
  // input is held back exactly while a result waits
  `ONB_ASSERT(a_stall_link, in_stall_o == out_wait, "input stall not tied to output stall")
  `ONB_ASSERT(a_out_hold, out_wait |=> (out_valid_o && $stable(fr_r_o) && $stable(pdf_o)), "stalled result changed")

endmodule

bind oren_nayar_brdf_eval onb_checker #(.DIR_BITS(DIR_BITS)) u_onb_checker (.*);
